// ===== src/u8d_pkg.sv =====
package u8d_pkg;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_BAD_LEAD = 3'd1,
		ST_BAD_CONT = 3'd2,
		ST_OVERLONG = 3'd3,
		ST_TRUNC    = 3'd4
	} u8d_status_t;

	localparam int unsigned CP_W = 21;

	localparam logic [CP_W-1:0] MIN_LEN2 = CP_W'(128);
	localparam logic [CP_W-1:0] MIN_LEN3 = CP_W'(2048);
	localparam logic [CP_W-1:0] MIN_LEN4 = CP_W'(65536);

	typedef struct packed {
		logic [1:0]      remaining;
		logic [2:0]      seq_len;
		logic [CP_W-1:0] partial;
	} u8d_state_t;

	typedef struct packed {
		logic            emit;
		logic [CP_W-1:0] code_point;
		u8d_status_t     status;
		logic            eos;
	} u8d_result_t;

endpackage

// ===== src/u8d_step.sv =====
module u8d_step
	import u8d_pkg::*;
(
	input  u8d_state_t  cur,
	input  logic [7:0]  in_byte,
	input  logic        last_byte,
	output u8d_state_t  nxt,
	output u8d_result_t res
);

	logic [CP_W-1:0] shifted;
	logic            overlong;

	assign shifted = {cur.partial[CP_W-7:0], in_byte[5:0]};

	always_comb begin
		case (cur.seq_len)
			3'd2:    overlong = shifted < MIN_LEN2;
			3'd3:    overlong = shifted < MIN_LEN3;
			3'd4:    overlong = shifted < MIN_LEN4;
			default: overlong = 1'b0;
		endcase
	end

	always_comb begin
		nxt            = '0;
		res.emit       = 1'b0;
		res.code_point = '0;
		res.status     = ST_OK;
		res.eos        = last_byte;
		if (cur.remaining == 2'd0) begin
			if (!in_byte[7]) begin
				res.emit       = 1'b1;
				res.code_point = {{(CP_W-8){1'b0}}, in_byte};
			end else if (in_byte[7:5] == 3'b110) begin
				nxt.partial   = {{(CP_W-5){1'b0}}, in_byte[4:0]};
				nxt.seq_len   = 3'd2;
				nxt.remaining = 2'd1;
			end else if (in_byte[7:4] == 4'b1110) begin
				nxt.partial   = {{(CP_W-4){1'b0}}, in_byte[3:0]};
				nxt.seq_len   = 3'd3;
				nxt.remaining = 2'd2;
			end else if (in_byte[7:3] == 5'b11110) begin
				nxt.partial   = {{(CP_W-3){1'b0}}, in_byte[2:0]};
				nxt.seq_len   = 3'd4;
				nxt.remaining = 2'd3;
			end else begin
				res.emit   = 1'b1;
				res.status = ST_BAD_LEAD;
			end
			// lead of a longer sequence on the final word
			if (last_byte && in_byte[7] && !res.emit) begin
				nxt        = '0;
				res.emit   = 1'b1;
				res.status = ST_TRUNC;
			end
		end else if (last_byte && cur.remaining > 2'd1) begin
			res.emit   = 1'b1;
			res.status = ST_TRUNC;
		end else if (in_byte[7:6] != 2'b10) begin
			res.emit   = 1'b1;
			res.status = ST_BAD_CONT;
		end else if (cur.remaining == 2'd1) begin
			res.emit = 1'b1;
			if (overlong) begin
				res.status = ST_OVERLONG;
			end else begin
				res.code_point = shifted;
			end
		end else begin
			nxt.partial   = shifted;
			nxt.seq_len   = cur.seq_len;
			nxt.remaining = cur.remaining - 2'd1;
		end
	end

endmodule

// ===== src/utf8_stream_decoder_core.sv =====
// utf8_stream_decoder_core: streaming UTF-8 to UTF-32 decoder
//
// input channel: in_valid/in_ready carry one word, in_byte plus last_byte,
// which marks the final byte of a string
// output channel: out_valid/out_ready carry code_point, status and
// end_of_string; status 0 is a good code point, 1 bad lead, 2 bad
// continuation, 3 overlong form, 4 string cut short; code_point is zero
// on any error
// a result appears only on the byte that completes or breaks a sequence,
// so lead and middle bytes of a multi-byte form give no output word
// each accepted byte is held in the input register and decoded into the
// result register once that register is free
// throughput: one byte per cycle unless the receiver stalls, set by the
// input register feeding the single decode step into the output register
// reset clears the valid flags and returns the decoder to waiting for a
// lead byte; a stalled receiver holds the output word, the input register
// still takes one more byte, then in_ready drops until out_ready returns
module utf8_stream_decoder_core
	import u8d_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      in_byte,
	input  logic            last_byte,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [CP_W-1:0] code_point,
	output logic [2:0]      status,
	output logic            end_of_string
);

	logic            valid_s1;
	logic [7:0]      byte_s1;
	logic            last_s1;
	u8d_state_t      state_q;
	u8d_state_t      state_nxt;
	u8d_result_t     res;
	logic            out_valid_q;
	logic [CP_W-1:0] cp_q;
	u8d_status_t     status_q;
	logic            eos_q;
	logic            out_free;
	logic            proc_s1;

	assign out_free = !out_valid_q || out_ready;
	assign proc_s1  = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	u8d_step u_step (
		.cur       (state_q),
		.in_byte   (byte_s1),
		.last_byte (last_s1),
		.nxt       (state_nxt),
		.res       (res)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			last_s1 <= last_byte;
		end
	end

	// sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (proc_s1) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= proc_s1 && res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (proc_s1 && res.emit) begin
			cp_q     <= res.code_point;
			status_q <= res.status;
			eos_q    <= res.eos;
		end
	end

	assign out_valid     = out_valid_q;
	assign code_point    = cp_q;
	assign status        = status_q;
	assign end_of_string = eos_q;

`ifndef SYNTH
	a_err_zero_cp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != ST_OK |-> cp_q == '0)
		else $error("error word with nonzero code point");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		proc_s1 && last_s1 |=> state_q.remaining == 2'd0)
		else $error("decoder not idle after final byte");

	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		proc_s1 && last_s1 |=> out_valid_q && eos_q)
		else $error("final byte gave no result word");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.remaining == 2'd0 |-> state_q.seq_len == 3'd0 && state_q.partial == '0)
		else $error("idle state holds stale sequence data");
`endif

endmodule

// ===== dv/utf8_stream_decoder_core_tb.sv =====
module utf8_stream_decoder_core_tb;
	import u8d_pkg::*;

	localparam int PROBE_N     = 23;
	localparam int RANDOM_N    = 500;
	localparam int GAP_MAX     = 13;
	localparam int DRAIN_LIMIT = 4000;
	localparam int PRINT_LIMIT = 60;

	typedef struct packed {
		logic [CP_W-1:0] cp;
		u8d_status_t     st;
		logic            eos;
	} cp_word_t;

	typedef struct packed {
		logic [7:0]      b;
		logic            lst;
		logic            fixed;
		logic [CP_W-1:0] cp;
		u8d_status_t     st;
		logic            eos;
	} probe_row_t;

	typedef enum int {
		SHAPE_CLEAN,
		SHAPE_OVERLONG,
		SHAPE_CUT,
		SHAPE_SPOILT,
		SHAPE_NOISE
	} shape_t;

	logic            clk;
	logic            arst_n;
	logic            in_valid;
	logic            in_ready;
	logic [7:0]      in_byte;
	logic            last_byte;
	logic            out_valid;
	logic            out_ready;
	logic [CP_W-1:0] code_point;
	logic [2:0]      status;
	logic            end_of_string;

	utf8_stream_decoder_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_byte      (in_byte),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.code_point   (code_point),
		.status       (status),
		.end_of_string(end_of_string)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// decoder state mirrored on the bench side
	logic [1:0]      bytes_left;
	logic [2:0]      form_len;
	logic [CP_W-1:0] acc;

	cp_word_t awaited_points[$];
	int       mismatches = 0;
	int       fed = 0;
	bit       push_hurry = 1'b0;
	bit       pull_hurry = 1'b0;

	probe_row_t probe_rows [PROBE_N] = '{
		'{8'h00, 1'b0, 1'b1, 21'h0,      ST_OK,       1'b0},
		'{8'h7f, 1'b1, 1'b1, 21'h7f,     ST_OK,       1'b1},
		'{8'h80, 1'b0, 1'b1, 21'h0,      ST_BAD_LEAD, 1'b0},
		'{8'hff, 1'b1, 1'b1, 21'h0,      ST_BAD_LEAD, 1'b1},
		'{8'hc2, 1'b0, 1'b0, 21'h0,      ST_OK,       1'b0},
		'{8'ha9, 1'b0, 1'b0, 21'h0,      ST_OK,       1'b0},
		'{8'hc0, 1'b0, 1'b0, 21'h0,      ST_OK,       1'b0},
		'{8'h80, 1'b0, 1'b1, 21'h0,      ST_OVERLONG, 1'b0},
		'{8'he2, 1'b0, 1'b0, 21'h0,      ST_OK,       1'b0},
		'{8'h82, 1'b0, 1'b0, 21'h0,      ST_OK,       1'b0},
		'{8'hac, 1'b1, 1'b0, 21'h0,      ST_OK,       1'b0},
		'{8'hf7, 1'b0, 1'b0, 21'h0,      ST_OK,       1'b0},
		'{8'hbf, 1'b0, 1'b0, 21'h0,      ST_OK,       1'b0},
		'{8'hbf, 1'b0, 1'b0, 21'h0,      ST_OK,       1'b0},
		'{8'hbf, 1'b0, 1'b0, 21'h0,      ST_OK,       1'b0},
		'{8'he2, 1'b1, 1'b1, 21'h0,      ST_TRUNC,    1'b1},
		'{8'hc3, 1'b0, 1'b0, 21'h0,      ST_OK,       1'b0},
		'{8'h41, 1'b0, 1'b1, 21'h0,      ST_BAD_CONT, 1'b0},
		'{8'hf0, 1'b0, 1'b0, 21'h0,      ST_OK,       1'b0},
		'{8'h41, 1'b1, 1'b1, 21'h0,      ST_TRUNC,    1'b1},
		'{8'he0, 1'b0, 1'b0, 21'h0,      ST_OK,       1'b0},
		'{8'h80, 1'b0, 1'b0, 21'h0,      ST_OK,       1'b0},
		'{8'h80, 1'b0, 1'b1, 21'h0,      ST_OVERLONG, 1'b0}
	};

	function automatic void clear_decoder();
		bytes_left = 2'd0;
		form_len   = 3'd0;
		acc        = '0;
	endfunction

	function automatic bit decode_byte(input logic [7:0] b, input logic lst,
			output cp_word_t w);
		logic [CP_W-1:0] floor_val;
		w = '{cp: '0, st: ST_OK, eos: lst};
		if (bytes_left == 2'd0) begin
			clear_decoder();
			if (!b[7]) begin
				w.cp = CP_W'(b);
				return 1'b1;
			end
			casez (b)
				8'b110?????: begin
					acc = CP_W'(b[4:0]);
					form_len = 3'd2;
					bytes_left = 2'd1;
				end
				8'b1110????: begin
					acc = CP_W'(b[3:0]);
					form_len = 3'd3;
					bytes_left = 2'd2;
				end
				8'b11110???: begin
					acc = CP_W'(b[2:0]);
					form_len = 3'd4;
					bytes_left = 2'd3;
				end
				default: begin
					w.st = ST_BAD_LEAD;
					return 1'b1;
				end
			endcase
			if (lst) begin
				clear_decoder();
				w.st = ST_TRUNC;
				return 1'b1;
			end
			return 1'b0;
		end
		if (lst && bytes_left > 2'd1) begin
			clear_decoder();
			w.st = ST_TRUNC;
			return 1'b1;
		end
		if (b[7:6] != 2'b10) begin
			clear_decoder();
			w.st = ST_BAD_CONT;
			return 1'b1;
		end
		acc = {acc[CP_W-7:0], b[5:0]};
		bytes_left = bytes_left - 2'd1;
		if (bytes_left != 2'd0)
			return 1'b0;
		case (form_len)
			3'd2:    floor_val = MIN_LEN2;
			3'd3:    floor_val = MIN_LEN3;
			default: floor_val = MIN_LEN4;
		endcase
		if (acc < floor_val)
			w.st = ST_OVERLONG;
		else
			w.cp = acc;
		clear_decoder();
		return 1'b1;
	endfunction

	task automatic flag_mismatch(input string what);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("mismatch at %0t: %s", $time, what);
	endtask

	// drive one word, wait for its handshake, then record what it should produce
	task automatic feed_byte(input logic [7:0] b, input logic lst,
			input bit use_typed, input cp_word_t typed);
		int       gap;
		bit       got;
		cp_word_t w;
		if ($urandom_range(0, 24) == 0)
			push_hurry = !push_hurry;
		gap = push_hurry ? 0 : $urandom_range(0, GAP_MAX);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		in_byte   <= b;
		last_byte <= lst;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		fed++;
		got = decode_byte(b, lst, w);
		if (use_typed) begin
			got = 1'b1;
			w = typed;
		end
		if (got)
			awaited_points.push_back(w);
	endtask

	initial begin
		probe_row_t      r;
		cp_word_t        none;
		shape_t          shape;
		int              pick;
		int              n;
		int              len;
		int              pos;
		int              waited;
		logic [CP_W-1:0] cp_val;
		logic [7:0]      form [4];
		logic            mark_end;

		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_byte   = 8'h00;
		last_byte = 1'b0;
		none      = '{cp: '0, st: ST_OK, eos: 1'b0};
		clear_decoder();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < PROBE_N; i++) begin
			r = probe_rows[i];
			feed_byte(r.b, r.lst, r.fixed, '{cp: r.cp, st: r.st, eos: r.eos});
		end

		while (fed < PROBE_N + RANDOM_N) begin
			pick = $urandom_range(0, 19);
			if (pick < 12)
				shape = SHAPE_CLEAN;
			else if (pick < 14)
				shape = SHAPE_OVERLONG;
			else if (pick < 16)
				shape = SHAPE_CUT;
			else if (pick < 18)
				shape = SHAPE_SPOILT;
			else
				shape = SHAPE_NOISE;

			n = (shape == SHAPE_CLEAN) ? $urandom_range(1, 4) : $urandom_range(2, 4);
			case (n)
				1:       cp_val = CP_W'($urandom_range(0, 127));
				2:       cp_val = CP_W'($urandom_range(128, 2047));
				3:       cp_val = CP_W'($urandom_range(2048, 65535));
				default: cp_val = CP_W'($urandom_range(65536, 21'h1fffff));
			endcase
			if (shape == SHAPE_OVERLONG) begin
				case (n)
					2:       cp_val = CP_W'($urandom_range(0, 127));
					3:       cp_val = CP_W'($urandom_range(0, 2047));
					default: cp_val = CP_W'($urandom_range(0, 65535));
				endcase
			end

			case (n)
				1: form[0] = {1'b0, cp_val[6:0]};
				2: begin
					form[0] = {3'b110, cp_val[10:6]};
					form[1] = {2'b10, cp_val[5:0]};
				end
				3: begin
					form[0] = {4'b1110, cp_val[15:12]};
					form[1] = {2'b10, cp_val[11:6]};
					form[2] = {2'b10, cp_val[5:0]};
				end
				default: begin
					form[0] = {5'b11110, cp_val[20:18]};
					form[1] = {2'b10, cp_val[17:12]};
					form[2] = {2'b10, cp_val[11:6]};
					form[3] = {2'b10, cp_val[5:0]};
				end
			endcase

			len = n;
			mark_end = ($urandom_range(0, 5) == 0);
			case (shape)
				SHAPE_CUT: begin
					len = $urandom_range(1, n - 1);
					mark_end = ($urandom_range(0, 3) != 0);
				end
				SHAPE_SPOILT: begin
					pos = $urandom_range(1, n - 1);
					form[pos] = 8'($urandom_range(0, 255));
					if (form[pos][7:6] == 2'b10)
						form[pos][6] = 1'b1;
				end
				SHAPE_NOISE: begin
					len = 1;
					form[0] = 8'($urandom_range(0, 255));
					mark_end = ($urandom_range(0, 3) == 0);
				end
				default: ;
			endcase

			for (int i = 0; i < len; i++)
				feed_byte(form[i], (i == len - 1) ? mark_end : 1'b0, 1'b0, none);
		end
		in_valid <= 1'b0;

		waited = 0;
		while (awaited_points.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		if (awaited_points.size() != 0)
			flag_mismatch($sformatf("%0d words never arrived", awaited_points.size()));
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// receiving side with random stalls
	initial begin
		int       stall;
		cp_word_t w;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 24) == 0)
				pull_hurry = !pull_hurry;
			stall = pull_hurry ? 0 : $urandom_range(0, GAP_MAX);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			if (awaited_points.size() == 0) begin
				flag_mismatch($sformatf("unexpected word cp=%0h status=%0d eos=%0b",
					code_point, status, end_of_string));
			end else begin
				w = awaited_points.pop_front();
				if (code_point !== w.cp)
					flag_mismatch($sformatf("code_point %0h, wanted %0h", code_point, w.cp));
				if (status !== w.st)
					flag_mismatch($sformatf("status %0d, wanted %s", status, w.st.name()));
				if (end_of_string !== w.eos)
					flag_mismatch($sformatf("end_of_string %0b, wanted %0b",
						end_of_string, w.eos));
			end
		end
	end

	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
src/u8d_pkg.sv
src/u8d_step.sv
src/utf8_stream_decoder_core.sv
dv/utf8_stream_decoder_core_tb.sv
